// ===== src/bmul_pkg.sv =====
// bmul_pkg: shared constants for the radix-2 booth multiplier
// no dependencies

package bmul_pkg;

    localparam int IN_W      = 16;
    localparam int OUT_W     = 32;
    localparam int DEF_WIDTH = 16;

    localparam logic [1:0] BOOTH_ADD = 2'b01;
    localparam logic [1:0] BOOTH_SUB = 2'b10;

endpackage

// ===== src/bmul_if.sv =====
// bmul_in_if, bmul_out_if: valid/ready channels of the booth multiplier
// depends on bmul_pkg for the field widths

interface bmul_in_if
    import bmul_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [IN_W-1:0]  multiplicand;
    logic signed [IN_W-1:0]  multiplier;

    modport source (output valid, output multiplicand, output multiplier, input ready);
    modport sink   (input valid, input multiplicand, input multiplier, output ready);
endinterface

interface bmul_out_if
    import bmul_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] product;

    modport source (output valid, output product, input ready);
    modport sink   (input valid, input product, output ready);
endinterface

// ===== src/booth_signed_multiplier.sv =====
// booth_signed_multiplier: radix-2 booth multiplier as a chain of WIDTH step cells
// depends on bmul_pkg, bmul_if (bmul_in_if, bmul_out_if) and bmul_cell
//
//  channel  dir  fields                        width
//  i_in     in   multiplicand, multiplier      16 + 16 signed
//  o_out    out  product                       32 signed
//
//  the product is taken from the last of the WIDTH cell registers, one booth step per cell
//  one transaction can enter every cycle while o_out is not stalled; the chain of WIDTH stage registers sets this
//  each cell advances when the next one is empty or moving, so bubbles fill under stall
//  the last cell's register is the output register
//  reset clears the stage valid bits only

module booth_signed_multiplier
    import bmul_pkg::*;
#(
    parameter int WIDTH = DEF_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bmul_in_if.sink    i_in,
    bmul_out_if.source o_out
);

    logic             w_valid [WIDTH+1];
    logic             w_ready [WIDTH+1];
    logic [WIDTH:0]   w_acc   [WIDTH+1];
    logic [WIDTH-1:0] w_q     [WIDTH+1];
    logic             w_qprev [WIDTH+1];
    logic [WIDTH-1:0] w_mcand [WIDTH+1];

    logic [WIDTH-1:0] w_op_a;
    logic [WIDTH-1:0] w_op_b;
    logic [2*WIDTH-1:0] w_prod;

    generate
        if (WIDTH <= IN_W) begin : g_cut
            assign w_op_a = i_in.multiplicand[WIDTH-1:0];
            assign w_op_b = i_in.multiplier[WIDTH-1:0];
        end else begin : g_ext
            assign w_op_a = {{(WIDTH-IN_W){i_in.multiplicand[IN_W-1]}}, i_in.multiplicand};
            assign w_op_b = {{(WIDTH-IN_W){i_in.multiplier[IN_W-1]}}, i_in.multiplier};
        end
    endgenerate

    assign w_valid[0] = i_in.valid;
    assign i_in.ready = w_ready[0];
    assign w_acc[0]   = '0;
    assign w_q[0]     = w_op_b;
    assign w_qprev[0] = 1'b0;
    assign w_mcand[0] = w_op_a;

    generate
        for (genvar g = 0; g < WIDTH; g++) begin : g_cell
            bmul_cell #(
                .WIDTH (WIDTH)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_valid[g]),
                .o_ready (w_ready[g]),
                .i_acc   (w_acc[g]),
                .i_q     (w_q[g]),
                .i_qprev (w_qprev[g]),
                .i_mcand (w_mcand[g]),
                .o_valid (w_valid[g+1]),
                .i_ready (w_ready[g+1]),
                .o_acc   (w_acc[g+1]),
                .o_q     (w_q[g+1]),
                .o_qprev (w_qprev[g+1]),
                .o_mcand (w_mcand[g+1])
            );
        end
    endgenerate

    assign w_ready[WIDTH] = o_out.ready;
    assign o_out.valid    = w_valid[WIDTH];

    assign w_prod = {w_acc[WIDTH][WIDTH-1:0], w_q[WIDTH]};

    generate
        if (2*WIDTH >= OUT_W) begin : g_trunc
            assign o_out.product = w_prod[OUT_W-1:0];
        end else begin : g_sext
            assign o_out.product = {{(OUT_W-2*WIDTH){w_prod[2*WIDTH-1]}}, w_prod};
        end
    endgenerate

endmodule

// ===== src/bmul_cell.sv =====
// bmul_cell: one booth step (add/sub/keep, then arithmetic shift) plus its stage register
// depends on bmul_pkg for the booth pair codes

module bmul_cell
    import bmul_pkg::*;
#(
    parameter int WIDTH = DEF_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH:0]   i_acc,
    input  logic [WIDTH-1:0] i_q,
    input  logic             i_qprev,
    input  logic [WIDTH-1:0] i_mcand,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH:0]   o_acc,
    output logic [WIDTH-1:0] o_q,
    output logic             o_qprev,
    output logic [WIDTH-1:0] o_mcand
);

    logic             r_valid;
    logic [WIDTH:0]   r_acc;
    logic [WIDTH-1:0] r_q;
    logic             r_qprev;
    logic [WIDTH-1:0] r_mcand;

    logic [WIDTH:0]   w_mcx;
    logic [WIDTH:0]   w_sum;
    logic [WIDTH:0]   n_acc;
    logic [WIDTH-1:0] n_q;

    assign w_mcx = {i_mcand[WIDTH-1], i_mcand};

    always_comb begin
        unique case ({i_q[0], i_qprev})
            BOOTH_ADD: w_sum = i_acc + w_mcx;
            BOOTH_SUB: w_sum = i_acc - w_mcx;
            default:   w_sum = i_acc;
        endcase
    end

    // arithmetic shift of acc:q right by one
    assign n_acc = {w_sum[WIDTH], w_sum[WIDTH:1]};
    assign n_q   = {w_sum[0], i_q[WIDTH-1:1]};

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_acc   <= n_acc;
            r_q     <= n_q;
            r_qprev <= i_q[0];
            r_mcand <= i_mcand;
        end
    end

    assign o_valid = r_valid;
    assign o_acc   = r_acc;
    assign o_q     = r_q;
    assign o_qprev = r_qprev;
    assign o_mcand = r_mcand;

endmodule

// ===== tb/booth_signed_multiplier_checker.sv =====
`timescale 1ns / 1ps
// booth_signed_multiplier_checker: watches both channels, predicts each product, compares
// depends on bmul_pkg and bmul_if (bmul_in_if, bmul_out_if)

module booth_signed_multiplier_checker
    import bmul_pkg::*;
#(
    parameter int WIDTH = DEF_WIDTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bmul_in_if   i_in,
    bmul_out_if  i_out,
    output int   o_fail_count,
    output int   o_pending
);

    logic [OUT_W-1:0] expected_products[$];

    // cut or sign-extend a 16-bit field to a signed WIDTH-bit operand held in 64 bits
    function automatic logic signed [63:0] fit_operand(input logic [IN_W-1:0] raw);
        logic signed [63:0] wide;
        wide = {{(64-IN_W){raw[IN_W-1]}}, raw};
        wide = (wide <<< (64 - WIDTH)) >>> (64 - WIDTH);
        return wide;
    endfunction

    function automatic logic [OUT_W-1:0] booth_product(input logic [IN_W-1:0] mcand_raw,
                                                       input logic [IN_W-1:0] mplier_raw);
        logic signed [63:0] mcand;
        logic signed [63:0] acc;
        logic        [63:0] q;
        logic        [63:0] full;
        logic        [1:0]  pair;
        logic               q_prev;
        mcand  = fit_operand(mcand_raw);
        q      = fit_operand(mplier_raw) & ((64'd1 << WIDTH) - 64'd1);
        acc    = '0;
        q_prev = 1'b0;
        for (int step = 0; step < WIDTH; step++) begin
            pair = {q[0], q_prev};
            if (pair == BOOTH_ADD) begin
                acc = acc + mcand;
            end else if (pair == BOOTH_SUB) begin
                acc = acc - mcand;
            end
            q_prev = q[0];
            q      = (q >> 1) | ({63'd0, acc[0]} << (WIDTH - 1));
            acc    = acc >>> 1;
        end
        full = (acc << WIDTH) | q;
        return full[OUT_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        logic [OUT_W-1:0] want;
        if (i_rst_n) begin
            if (i_out.valid && i_out.ready) begin
                if (expected_products.size() == 0) begin
                    $error("product with no transaction waiting: actual %0d",
                           $signed(i_out.product));
                    o_fail_count++;
                end else begin
                    want = expected_products.pop_front();
                    if (i_out.product !== want) begin
                        $error("product mismatch: expected %0d, actual %0d",
                               $signed(want), $signed(i_out.product));
                        o_fail_count++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                expected_products.push_back(booth_product(i_in.multiplicand,
                                                          i_in.multiplier));
            end
            o_pending = expected_products.size();
        end
    end

endmodule

// ===== tb/booth_signed_multiplier_tb.sv =====
`timescale 1ns / 1ps
// booth_signed_multiplier_tb: operand stimulus, output back-pressure and final verdict
// depends on bmul_pkg, bmul_if, booth_signed_multiplier and booth_signed_multiplier_checker

module booth_signed_multiplier_tb
    import bmul_pkg::*;
();

    localparam int WIDTH       = DEF_WIDTH;
    localparam int HOLD_CYCLES = 4 * WIDTH + 30;
    localparam int STALL_LIMIT = 2000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   idle_cycles;
    int   hold_left;
    bit   hold_request;
    bit   hold_taken;

    logic signed [IN_W-1:0] corner_values[5] = '{16'sh8000, -16'sd1, 16'sd0, 16'sd1, 16'sh7fff};

    bmul_in_if  in_ch();
    bmul_out_if out_ch();

    booth_signed_multiplier #(.WIDTH(WIDTH)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    booth_signed_multiplier_checker #(.WIDTH(WIDTH)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic logic [IN_W-1:0] pick_operand();
        case ($urandom_range(9))
            0: return corner_values[$urandom_range(4)];
            1: return IN_W'($signed($urandom_range(8)) - 4);
            2: return $urandom_range(1) ? 16'haaaa : 16'h5555;
            default: return IN_W'($urandom);
        endcase
    endfunction

    task automatic offer_operands(input logic [IN_W-1:0] mcand, input logic [IN_W-1:0] mplier);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.multiplicand <= mcand;
        in_ch.multiplier   <= mplier;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    task automatic offer_random(input int count);
        for (int n = 0; n < count; n++) begin
            offer_operands(pick_operand(), pick_operand());
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        out_ch.ready = 1'b0;
        hold_left    = 0;
        hold_taken   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (hold_request && !hold_taken) begin
                hold_taken   = 1'b1;
                hold_left    = HOLD_CYCLES - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.multiplicand = '0;
        in_ch.multiplier   = '0;
        hold_request       = 1'b0;
        send_idle_pct      = 25;
        recv_idle_pct      = 61;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // corner values of both operands against each other
        foreach (corner_values[i]) begin
            foreach (corner_values[j]) begin
                offer_operands(corner_values[i], corner_values[j]);
            end
        end
        wait_drained();

        offer_random(450);

        send_idle_pct = 61;
        recv_idle_pct = 25;
        offer_random(450);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        offer_random(150);
        hold_request = 1'b1;
        offer_random(350);

        wait_drained();
        repeat (WIDTH + 4) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
